// ===== rtl/cpr_pkg.sv =====
`default_nettype none

package cpr_pkg;

  // Sizes of the frame table and of the address split.
  localparam int MaxFrames   = 64;
  localparam int FrameBits   = $clog2(MaxFrames);
  localparam int NumBits     = FrameBits + 1;
  localparam int PageBits    = 12;
  localparam int AddrBits    = 32;
  localparam int PageNumBits = AddrBits - PageBits;
  localparam int CountBits   = 32;
  localparam int CfgBits     = 7;

  // Access kinds.
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // One access request.
  typedef struct packed {
    logic                cmd;
    logic [AddrBits-1:0] address;
  } cpr_in_t;

  // One access result.
  typedef struct packed {
    logic                   hit;
    logic [FrameBits-1:0]   frame;
    logic                   evicted;
    logic [PageNumBits-1:0] evicted_page;
    logic                   write_back;
    logic                   disk_read;
    logic [CountBits-1:0]   event_total;
    logic [CountBits-1:0]   read_total;
    logic [CountBits-1:0]   write_total;
  } cpr_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic scan_init;
    logic scan_step;
    logic do_hit;
    logic do_fill;
    logic sweep_step;
    logic do_evict;
  } cpr_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit_now;
    logic scan_end;
    logic empty_any;
    logic sweep_found;
  } cpr_stat_t;

  // Controller states.
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_SWEEP = 5'b00100,
    ST_EVICT = 5'b01000,
    ST_DONE  = 5'b10000
  } cpr_state_t;

endpackage

`default_nettype wire

// ===== rtl/cpr_ram.sv =====
`default_nettype none

module cpr_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/cpr_datapath.sv =====
`default_nettype none

module cpr_datapath (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire cpr_pkg::cpr_in_t           req,
  input  wire logic                       cfg_we,
  input  wire logic [cpr_pkg::CfgBits-1:0] cfg_wdata,
  input  wire cpr_pkg::cpr_ctl_t          ctl,
  output cpr_pkg::cpr_stat_t              stat,
  output cpr_pkg::cpr_out_t               rsp
);

  import cpr_pkg::*;

  logic [CfgBits-1:0]     frames_cfg;
  logic [NumBits-1:0]     n_active;
  logic [NumBits-1:0]     last_idx;
  logic [MaxFrames-1:0]   full;
  logic [MaxFrames-1:0]   dirty;
  logic [MaxFrames-1:0]   refb;
  logic [FrameBits-1:0]   hand;
  logic [CountBits-1:0]   event_count;
  logic [CountBits-1:0]   read_count;
  logic [CountBits-1:0]   write_count;
  logic [PageNumBits-1:0] req_page;
  logic                   req_write;
  logic [FrameBits-1:0]   rd_idx;
  logic                   cmp_valid;
  logic [FrameBits-1:0]   cmp_idx;
  logic                   empty_found;
  logic [FrameBits-1:0]   empty_idx;
  logic [FrameBits-1:0]   empty_slot;
  logic                   cmp_empty;
  logic [FrameBits-1:0]   sweep_slot;
  logic [FrameBits-1:0]   victim;
  logic                   ram_we;
  logic [FrameBits-1:0]   ram_waddr;
  logic [FrameBits-1:0]   ram_raddr;
  logic [PageNumBits-1:0] ram_rdata;
  logic                   victim_dirty;

  // Effective frame count: zero acts as one, large values saturate.
  always_comb begin
    if (frames_cfg == '0) begin
      n_active = NumBits'(1);
    end else if (NumBits'(frames_cfg) > NumBits'(MaxFrames)) begin
      n_active = NumBits'(MaxFrames);
    end else begin
      n_active = NumBits'(frames_cfg);
    end
  end

  assign last_idx = n_active - NumBits'(1);

  // Lookup compare on the frame read in the previous cycle.
  assign cmp_empty        = cmp_valid && !full[cmp_idx];
  assign stat.hit_now     = cmp_valid && full[cmp_idx] && (ram_rdata == req_page);
  assign stat.scan_end    = cmp_valid && ({1'b0, cmp_idx} == last_idx);
  assign stat.empty_any   = empty_found || cmp_empty;
  assign empty_slot       = empty_found ? empty_idx : cmp_idx;

  // The hand restarts at frame zero when it points past the frame count.
  assign sweep_slot       = ({1'b0, hand} >= n_active) ? '0 : hand;
  assign stat.sweep_found = !refb[sweep_slot];

  assign victim_dirty = dirty[victim];

  // Page number store.
  assign ram_we    = ctl.do_fill || ctl.do_evict;
  assign ram_waddr = ctl.do_evict ? victim : empty_slot;
  assign ram_raddr = ctl.sweep_step ? sweep_slot : rd_idx;

  cpr_ram #(
    .Width(PageNumBits),
    .Depth(MaxFrames)
  ) u_page_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(req_page),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Configuration, frame flags, hand and running counts.
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_cfg  <= CfgBits'(MaxFrames);
      full        <= '0;
      dirty       <= '0;
      refb        <= '0;
      hand        <= '0;
      event_count <= '0;
      read_count  <= '0;
      write_count <= '0;
    end else begin
      if (cfg_we) begin
        frames_cfg <= cfg_wdata;
      end
      if (ctl.do_hit) begin
        refb[cmp_idx] <= 1'b1;
        if (req_write == CMD_WRITE) begin
          dirty[cmp_idx] <= 1'b1;
        end
        event_count <= event_count + CountBits'(1);
      end
      if (ctl.do_fill) begin
        full[empty_slot]  <= 1'b1;
        dirty[empty_slot] <= req_write;
        refb[empty_slot]  <= 1'b1;
        event_count       <= event_count + CountBits'(1);
        read_count        <= read_count + CountBits'(1);
      end
      if (ctl.sweep_step) begin
        if (stat.sweep_found) begin
          hand <= sweep_slot;
        end else begin
          refb[sweep_slot] <= 1'b0;
          hand             <= sweep_slot + FrameBits'(1);
        end
      end
      if (ctl.do_evict) begin
        full[victim]  <= 1'b1;
        dirty[victim] <= req_write;
        refb[victim]  <= 1'b1;
        event_count   <= event_count + CountBits'(1);
        read_count    <= read_count + CountBits'(1);
        if (victim_dirty) begin
          write_count <= write_count + CountBits'(1);
        end
      end
    end
  end

  // Scan pipeline: one frame read issued per cycle, compared in the cycle after.
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_valid   <= 1'b0;
      empty_found <= 1'b0;
    end else if (ctl.scan_init) begin
      cmp_valid   <= 1'b0;
      empty_found <= 1'b0;
    end else if (ctl.scan_step) begin
      cmp_valid <= 1'b1;
      if (cmp_empty && !empty_found) begin
        empty_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.scan_init) begin
      req_page  <= req.address[AddrBits-1:PageBits];
      req_write <= req.cmd;
      rd_idx    <= '0;
    end else if (ctl.scan_step) begin
      rd_idx  <= rd_idx + FrameBits'(1);
      cmp_idx <= rd_idx;
      if (cmp_empty && !empty_found) begin
        empty_idx <= cmp_idx;
      end
    end
    if (ctl.sweep_step && stat.sweep_found) begin
      victim <= sweep_slot;
    end
  end

  // Result register, loaded in the cycle that finishes an access.
  always_ff @(posedge clk) begin
    if (ctl.do_hit) begin
      rsp.hit          <= 1'b1;
      rsp.frame        <= cmp_idx;
      rsp.evicted      <= 1'b0;
      rsp.evicted_page <= '0;
      rsp.write_back   <= 1'b0;
      rsp.disk_read    <= 1'b0;
      rsp.event_total  <= event_count + CountBits'(1);
      rsp.read_total   <= read_count;
      rsp.write_total  <= write_count;
    end else if (ctl.do_fill) begin
      rsp.hit          <= 1'b0;
      rsp.frame        <= empty_slot;
      rsp.evicted      <= 1'b0;
      rsp.evicted_page <= '0;
      rsp.write_back   <= 1'b0;
      rsp.disk_read    <= 1'b1;
      rsp.event_total  <= event_count + CountBits'(1);
      rsp.read_total   <= read_count + CountBits'(1);
      rsp.write_total  <= write_count;
    end else if (ctl.do_evict) begin
      rsp.hit          <= 1'b0;
      rsp.frame        <= victim;
      rsp.evicted      <= 1'b1;
      rsp.evicted_page <= ram_rdata;
      rsp.write_back   <= victim_dirty;
      rsp.disk_read    <= 1'b1;
      rsp.event_total  <= event_count + CountBits'(1);
      rsp.read_total   <= read_count + CountBits'(1);
      rsp.write_total  <= write_count + CountBits'(victim_dirty);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cpr_ctrl.sv =====
`default_nettype none

module cpr_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire cpr_pkg::cpr_stat_t stat,
  output cpr_pkg::cpr_ctl_t       ctl,
  output logic                    busy,
  output logic                    done
);

  import cpr_pkg::*;

  cpr_state_t state;
  cpr_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencing: lookup scan, then fill, hit update or clock sweep and eviction.
  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          ctl.scan_init = 1'b1;
          state_next    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        ctl.scan_step = 1'b1;
        if (stat.hit_now) begin
          ctl.do_hit = 1'b1;
          state_next = ST_DONE;
        end else if (stat.scan_end) begin
          if (stat.empty_any) begin
            ctl.do_fill = 1'b1;
            state_next  = ST_DONE;
          end else begin
            state_next = ST_SWEEP;
          end
        end
      end
      ST_SWEEP: begin
        ctl.sweep_step = 1'b1;
        if (stat.sweep_found) begin
          state_next = ST_EVICT;
        end
      end
      ST_EVICT: begin
        ctl.do_evict = 1'b1;
        state_next   = ST_DONE;
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);
  assign done = (state == ST_DONE);

endmodule

`default_nettype wire

// ===== rtl/clock_page_replacement.sv =====
`default_nettype none

// Channel    Ports                 Transfer
// request    start, busy, req      rising edge with start high and busy low
// result     done, rsp             rising edge ending the cycle done is high
// config     cfg_we, cfg_wdata     rising edge with cfg_we high
//
// An access runs the lookup scan, which reads one frame from the page store
// per cycle and ends at a hit or, on a miss, after the last frame. An eviction
// adds the clock sweep, whose last read fetches the victim page, and then the
// eviction step; the next access can transfer in the cycle after the result.
// Reset is synchronous and empties all frames. The result is shown for one
// cycle with done and cannot be held off.

module clock_page_replacement (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire cpr_pkg::cpr_in_t            req,
  output logic                             done,
  output cpr_pkg::cpr_out_t                rsp,
  input  wire logic                        cfg_we,
  input  wire logic [cpr_pkg::CfgBits-1:0] cfg_wdata
);

  import cpr_pkg::*;

  cpr_ctl_t  ctl;
  cpr_stat_t stat;

  // Sequencer.
  cpr_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .stat (stat),
    .ctl  (ctl),
    .busy (busy),
    .done (done)
  );

  // Frame table, hand, counters and result register.
  cpr_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .ctl      (ctl),
    .stat     (stat),
    .rsp      (rsp)
  );

endmodule

`default_nettype wire
